[hw/rtl/rrtr_pkg.sv]
// rrtr_pkg: shared types, action and status codes for the round-robin turn ring.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package rrtr_pkg;

	// Default ring capacity
	localparam int MAX_MEMBERS_DEF = 16;

	// Depth of the command queue between front and back
	localparam int CMD_DEPTH = 2;

	// Action codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_NEXT   = 2'd2;
	localparam logic [1:0] OP_SKIP   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Input beat
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] member_id;
	} in_item_t;

	// Classified command carried from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] id;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] turn_member;
		logic [15:0] skipped_member;
		logic        sole_remaining;
		logic [4:0]  member_count;
	} res_t;

endpackage

[hw/rtl/rrtr_front.sv]
// rrtr_front: accepts input beats and classifies them into commands.
// Depends on rrtr_pkg; feeds rrtr_cmd_queue.
`timescale 1ns / 1ps

module rrtr_front import rrtr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_cls;

	// Classify: only add and remove carry an id
	always_comb begin
		cmd_cls.op = item.action;
		if (item.action inside {OP_ADD, OP_REMOVE}) begin
			cmd_cls.id = item.member_id;
		end else begin
			cmd_cls.id = '0;
		end
	end

	// Stall while the held command cannot enter the queue
	assign full   = valid_s1 && q_full;
	assign q_push = valid_s1;
	assign q_cmd  = cmd_s1;

	// Hold or advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	// Capture the classified command
	always_ff @(posedge clk) begin
		if (!full && push) begin
			cmd_s1 <= cmd_cls;
		end
	end

endmodule

[hw/rtl/rrtr_cmd_queue.sv]
// rrtr_cmd_queue: short command queue between front and back.
// Depends on rrtr_pkg for cmd_t and CMD_DEPTH.
`timescale 1ns / 1ps

module rrtr_cmd_queue import rrtr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	output logic q_full,
	input  logic pop,
	output logic q_empty,
	output cmd_t head
);

	localparam int PTRW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNTW = $clog2(CMD_DEPTH + 1);

	cmd_t            slots_q [CMD_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign q_full  = (fill_q == CNTW'(CMD_DEPTH));
	assign q_empty = (fill_q == '0);
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !q_full;
	assign do_pop  = pop && !q_empty;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

[hw/rtl/rrtr_exec.sv]
// rrtr_exec: executes ring commands on the id memory and holds the result beat.
// Depends on rrtr_pkg; takes commands from rrtr_cmd_queue.
`timescale 1ns / 1ps

module rrtr_exec import rrtr_pkg::*; #(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output res_t result,
	output logic empty,
	input  logic pop
);

	localparam int PW = $clog2(MAX_MEMBERS);
	localparam int CW = $clog2(MAX_MEMBERS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SRCH  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_TRD   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]    state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] turn_q;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] hit_q;
	logic [1:0]    status_q;
	logic [15:0]   skipped_q;
	logic [15:0]   rd_data_q;
	res_t          res_q;
	logic          res_valid_q;

	logic [15:0]   mem [MAX_MEMBERS];

	logic [PW-1:0] rd_addr;
	logic [PW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          wr_en;

	logic [CW-1:0] t1;
	logic [PW-1:0] wrap1;
	logic [CW:0]   t2;
	logic [CW:0]   t2_sub;
	logic [PW-1:0] wrap2;
	logic [CW-1:0] idx_nxt;
	logic          last;
	logic          ring_full;
	logic          ring_empty;
	logic          out_free;

	assign ring_full  = (count_q == CW'(MAX_MEMBERS));
	assign ring_empty = (count_q == '0);
	assign out_free   = !res_valid_q || pop;
	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign result     = res_q;
	assign empty      = !res_valid_q;

	// Turn one and two ahead, wrapped by the member count
	assign t1     = CW'(turn_q) + CW'(1);
	assign wrap1  = (t1 == count_q) ? '0 : t1[PW-1:0];
	assign t2     = (CW + 1)'(turn_q) + (CW + 1)'(2);
	assign t2_sub = t2 - {1'b0, count_q};
	always_comb begin
		if (count_q == CW'(1)) begin
			wrap2 = '0;
		end else if (t2 >= {1'b0, count_q}) begin
			wrap2 = t2_sub[PW-1:0];
		end else begin
			wrap2 = t2[PW-1:0];
		end
	end

	// Scan index and end of occupied slots
	assign idx_nxt = CW'(idx_q) + CW'(1);
	assign last    = (idx_nxt == count_q);

	// Drive memory read and write ports
	always_comb begin
		rd_addr = turn_q;
		wr_en   = 1'b0;
		wr_addr = count_q[PW-1:0];
		wr_data = cmd_q.id;
		case (state_q)
			S_EXEC: begin
				if (cmd_q.op == OP_ADD && !ring_full) begin
					wr_en = 1'b1;
				end
				if (cmd_q.op == OP_SKIP) begin
					rd_addr = wrap1;
				end else if (cmd_q.op == OP_REMOVE) begin
					rd_addr = '0;
				end
			end
			S_SRCH: begin
				rd_addr = idx_nxt[PW-1:0];
			end
			S_SHIFT: begin
				if (!last) begin
					wr_en   = 1'b1;
					wr_addr = idx_q;
					wr_data = rd_data_q;
					rd_addr = idx_q + PW'(2);
				end
			end
			default: begin
				rd_addr = turn_q;
			end
		endcase
	end

	// Id memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Latch the command taken from the queue
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	// Sequence each command and update ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			turn_q    <= '0;
			idx_q     <= '0;
			hit_q     <= '0;
			status_q  <= ST_OK;
			skipped_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q  <= ST_OK;
					skipped_q <= '0;
					state_q   <= S_TRD;
					case (cmd_q.op)
						OP_ADD: begin
							if (ring_full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_REMOVE: begin
							if (ring_empty) begin
								status_q <= ST_EMPTY;
							end else begin
								idx_q   <= '0;
								state_q <= S_SRCH;
							end
						end
						OP_NEXT: begin
							if (ring_empty) begin
								status_q <= ST_EMPTY;
							end else begin
								turn_q <= wrap1;
							end
						end
						default: begin
							if (ring_empty) begin
								status_q <= ST_EMPTY;
							end else begin
								turn_q <= wrap2;
							end
						end
					endcase
				end
				S_SRCH: begin
					if (rd_data_q == cmd_q.id) begin
						hit_q   <= idx_q;
						state_q <= S_SHIFT;
					end else if (last) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_TRD;
					end else begin
						idx_q <= idx_nxt[PW-1:0];
					end
				end
				S_SHIFT: begin
					if (!last) begin
						idx_q <= idx_nxt[PW-1:0];
					end else begin
						// Drop the member and repair the turn
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							turn_q <= '0;
						end else if (hit_q < turn_q) begin
							turn_q <= turn_q - 1'b1;
						end else if (hit_q == turn_q && t1 == count_q) begin
							turn_q <= '0;
						end
						state_q <= S_TRD;
					end
				end
				S_TRD: begin
					if (cmd_q.op == OP_SKIP && !ring_empty) begin
						skipped_q <= rd_data_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the result beat until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			res_q.status         <= status_q;
			res_q.turn_member    <= ring_empty ? 16'd0 : rd_data_q;
			res_q.skipped_member <= skipped_q;
			res_q.sole_remaining <= (count_q == CW'(1));
			res_q.member_count   <= 5'(count_q);
		end
	end

endmodule

[hw/rtl/round_robin_turn_ring.sv]
// round_robin_turn_ring: top level of the round-robin turn ring.
// Depends on rrtr_pkg, rrtr_front, rrtr_cmd_queue and rrtr_exec.
//
//   channel  | handshake        | beat moves when  | payload
//   ---------+------------------+------------------+----------------
//   input    | push / full      | push && !full    | item   (in_item_t)
//   result   | empty / pop      | pop && !empty    | result (res_t)
//
// Add, next, skip and remove on an empty ring pass through the exec, turn-read
// and finish states of the back end. Remove on a non-empty ring also searches,
// and shifts the later members down when the id is found, slot by slot; the
// single read port of the id memory sets this: search and shift walk the ring once.
// Reset clears counts, turn and queues at once; no clearing pass.
// The front stage and a two-entry command queue keep taking beats while the
// back end works or a result waits; once both are full, the input stalls too.
`timescale 1ns / 1ps

module round_robin_turn_ring import rrtr_pkg::*; #(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     empty,
	input  logic     pop,
	output res_t     result
);

	logic q_push;
	cmd_t q_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t q_head;

	// Accept and classify
	rrtr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	// Decouple front from back
	rrtr_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (q_cmd),
		.q_full  (q_full),
		.pop     (q_pop),
		.q_empty (q_empty),
		.head    (q_head)
	);

	// Execute on the ring
	rrtr_exec #(
		.MAX_MEMBERS (MAX_MEMBERS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

[tb/sv/tb_round_robin_turn_ring.sv]
// tb_round_robin_turn_ring: self-checking testbench for the round-robin turn ring.
// Depends on rrtr_pkg and round_robin_turn_ring; runs directed cases, then random
// traffic with idle/stall phases and a long result hold-off.
`timescale 1ns / 1ps

module tb_round_robin_turn_ring;
	import rrtr_pkg::*;

	localparam int RING_CAP    = MAX_MEMBERS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 80;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     push   = 1'b0;
	in_item_t item   = '0;
	logic     pop    = 1'b0;
	logic     full;
	logic     empty;
	res_t     result;

	// Mirror of the ring contents as beats are accepted
	logic [15:0] member_slots [RING_CAP];
	int          member_total = 0;
	int          turn_slot    = 0;

	res_t outcome_fifo [$];
	int   errors        = 0;
	int   cycle_count   = 0;
	int   send_idle_pct = 0;
	int   pop_stall_pct = 0;
	int   hold_seq      = 0;

	round_robin_turn_ring #(
		.MAX_MEMBERS(RING_CAP)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("round_robin_turn_ring test failed");
			$finish;
		end
	end

	// Apply one action to the mirrored ring and return the result it yields
	function automatic res_t ring_apply(in_item_t it);
		res_t r;
		int   hit;
		r        = '0;
		r.status = ST_OK;
		hit      = -1;
		case (it.action)
			OP_ADD: begin
				if (member_total >= RING_CAP) begin
					r.status = ST_FULL;
				end else begin
					member_slots[member_total] = it.member_id;
					if (member_total == 0)
						turn_slot = 0;
					member_total++;
				end
			end
			OP_REMOVE: begin
				if (member_total == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// Find the match nearest the head
					for (int i = member_total - 1; i >= 0; i--)
						if (member_slots[i] == it.member_id)
							hit = i;
					if (hit < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						for (int i = hit; i + 1 < member_total; i++)
							member_slots[i] = member_slots[i + 1];
						member_total--;
						if (member_total == 0)
							turn_slot = 0;
						else if (hit < turn_slot)
							turn_slot--;
						else if (hit == turn_slot)
							turn_slot = turn_slot % member_total;
					end
				end
			end
			OP_NEXT: begin
				if (member_total == 0)
					r.status = ST_EMPTY;
				else
					turn_slot = (turn_slot + 1) % member_total;
			end
			OP_SKIP: begin
				if (member_total == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.skipped_member = member_slots[(turn_slot + 1) % member_total];
					turn_slot        = (turn_slot + 2) % member_total;
				end
			end
			default: ;
		endcase
		if (member_total != 0)
			r.turn_member = member_slots[turn_slot % member_total];
		r.sole_remaining = (member_total == 1);
		r.member_count   = 5'(member_total);
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offer one beat, idling first at the current rate; predict on acceptance
	task automatic send_item(input logic [1:0] act, input logic [15:0] id);
		in_item_t it;
		it.action    = act;
		it.member_id = id;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		outcome_fifo.push_back(ring_apply(it));
	endtask

	// Pop results, compare against the oldest prediction, drive pop
	initial begin : result_check
		res_t want;
		int   hold_seen;
		int   hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (outcome_fifo.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0h",
						$time, result);
					errors++;
				end else begin
					want = outcome_fifo.pop_front();
					check_field("status", want.status, result.status);
					check_field("turn_member", want.turn_member, result.turn_member);
					check_field("skipped_member", want.skipped_member,
						result.skipped_member);
					check_field("sole_remaining", want.sole_remaining,
						result.sole_remaining);
					check_field("member_count", want.member_count, result.member_count);
				end
			end
			// Start a hold-off when one is requested
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= pop_stall_pct);
			end
		end
	end

	// Next, skip and remove on an empty ring
	task automatic test_empty_ring();
		send_item(OP_REMOVE, 16'h0000);
		send_item(OP_NEXT, 16'hFFFF);
		send_item(OP_SKIP, 16'h1234);
	endtask

	// One member: it takes the turn, is its own skip, then leaves
	task automatic test_single_member();
		send_item(OP_ADD, 16'h0000);
		send_item(OP_SKIP, 16'h0000);
		send_item(OP_NEXT, 16'h0000);
		send_item(OP_REMOVE, 16'hFFFF);
		send_item(OP_REMOVE, 16'h0000);
	endtask

	// Fill with a duplicate, overflow, then remove the turn holder by duplicate id
	task automatic test_full_ring();
		send_item(OP_ADD, 16'h0001);
		send_item(OP_ADD, 16'hFFFF);
		send_item(OP_ADD, 16'h0001);
		send_item(OP_ADD, 16'h8000);
		for (int i = 4; i < RING_CAP; i++)
			send_item(OP_ADD, 16'h0100 + 16'(i));
		send_item(OP_ADD, 16'h0002);
		send_item(OP_REMOVE, 16'h0001);
	endtask

	// Random traffic steered toward a drifting ring size
	task automatic test_random_mix(input int beats, input int idle_pct, input int stall_pct);
		int          goal;
		int          r;
		int          add_w;
		int          rem_w;
		logic [1:0]  act;
		logic [15:0] id;
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		goal          = $urandom_range(RING_CAP);
		for (int n = 0; n < beats; n++) begin
			if (n % 40 == 0)
				goal = $urandom_range(RING_CAP);
			add_w = (member_total < goal) ? 55 : 10;
			rem_w = (member_total > goal) ? 55 : 20;
			r     = $urandom_range(99);
			if (r < add_w)
				act = OP_ADD;
			else if (r < add_w + rem_w)
				act = OP_REMOVE;
			else if (r < add_w + rem_w + (100 - add_w - rem_w) / 2)
				act = OP_NEXT;
			else
				act = OP_SKIP;
			// Mostly hit present ids on remove; keep a few small ids for duplicates
			if (act == OP_REMOVE && member_total > 0 && $urandom_range(99) < 80)
				id = member_slots[$urandom_range(member_total - 1)];
			else if ($urandom_range(99) < 30)
				id = 16'($urandom_range(3));
			else
				id = 16'($urandom_range(16'hFFFF));
			send_item(act, id);
		end
	endtask

	// Hold the result side off while beats keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		hold_seq++;
		test_random_mix(30, 0, 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ring();
		test_single_member();
		test_full_ring();
		test_random_mix(405, 0, 0);
		test_random_mix(405, 85, 0);
		test_random_mix(405, 0, 85);
		test_random_mix(405, 20, 20);
		test_backpressure();
		push          <= 1'b0;
		pop_stall_pct = 0;
		while (outcome_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("round_robin_turn_ring test passed");
		else
			$display("round_robin_turn_ring test failed");
		$finish;
	end

endmodule
